/* hdl/kcat_pkg.sv */
// ---------------------------------------------------------------------------
// Key chord action trigger package
// Shared types and codes for the chord matcher and its action queue.
// ---------------------------------------------------------------------------
package kcat_pkg;

  localparam logic [2:0] OP_PRESS   = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_POP     = 3'd2;
  localparam logic [2:0] OP_WR_TRIG = 3'd3;
  localparam logic [2:0] OP_WR_REQ  = 3'd4;

  localparam logic [1:0] KS_RELEASED = 2'd0;
  localparam logic [1:0] KS_FRESH    = 2'd1;
  localparam logic [1:0] KS_HELD     = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] key_code;
    logic [47:0] time_ms;
    logic [47:0] till_ms;
    logic [3:0]  trigger_slot;
    logic [1:0]  requirement_slot;
    logic        entry_enable;
    logic [7:0]  entry_action;
    logic [15:0] entry_key;
    logic        entry_needs_fresh;
  } item_t;

  typedef struct packed {
    logic       any_triggered;
    logic       popped_valid;
    logic [7:0] popped_action;
    logic       queue_dropped;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [7:0] action;
  } trig_entry_t;

  typedef struct packed {
    logic        en;
    logic        fresh;
    logic [15:0] key;
    logic [1:0]  ks;
  } req_entry_t;

  typedef struct packed {
    logic [7:0]  action;
    logic [47:0] time_ms;
  } qentry_t;

  typedef struct packed {
    logic push;
    logic rd;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_sts_t;

endpackage

/* hdl/kcat_queue.sv */
// ---------------------------------------------------------------------------
// Action queue
// Circular buffer of triggered actions held in one synchronous memory.
// ---------------------------------------------------------------------------
module kcat_queue #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  kcat_pkg::queue_ctl_t ctl,
  input  kcat_pkg::qentry_t   wdata,
  output kcat_pkg::qentry_t   rdata,
  output kcat_pkg::queue_sts_t sts
);
  import kcat_pkg::*;

  localparam int QW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qentry_t         mem [DEPTH];
  logic [QW-1:0]   head;
  logic [CW-1:0]   count;
  logic [QW:0]     sum;
  logic [QW-1:0]   tail;

  always_comb begin
    sum = (QW + 1)'(head) + (QW + 1)'(count);
    if (sum >= (QW + 1)'(DEPTH)) begin
      sum = sum - (QW + 1)'(DEPTH);
    end
    tail = sum[QW-1:0];
  end

  assign sts.empty = (count == '0);
  assign sts.full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (ctl.pop) begin
        head <= (head == QW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
        count <= count + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !sts.full) else $error("Transfer pushed into a full queue.");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !sts.empty) else $error("Queue popped while empty.");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("Queue count exceeds its depth.");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (ctl.push && !ctl.pop) |=> count == $past(count) + 1'b1)
    else $error("Queue count did not grow after a push.");
`endif

endmodule

/* hdl/key_chord_action_trigger_unit.sv */
// ---------------------------------------------------------------------------
// Key chord action trigger unit
// Matches key chords against a trigger table and queues triggered actions.
// ---------------------------------------------------------------------------
// One item is taken at a time. A press or release walks every requirement
// slot of every trigger through the table memory, a read state and then an
// execute state per slot; a pop reads the queue head and then checks it,
// skipping the check when the queue is empty, and a table write goes straight
// to its result. A result that waits for the response transfer holds the next
// item back until it is taken. After reset a clearing pass empties the
// tables, during which no item is taken.
module key_chord_action_trigger_unit #(
  parameter int TRIGGERS    = 16,
  parameter int REQS        = 4,
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  kcat_pkg::item_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output kcat_pkg::result_t rsp
);
  import kcat_pkg::*;

  localparam int TW = (TRIGGERS > 1) ? $clog2(TRIGGERS) : 1;
  localparam int RW = (REQS > 1) ? $clog2(REQS) : 1;
  localparam int AW = TW + RW;
  localparam int RDEPTH = TRIGGERS * (2 ** RW);

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_EX     = 3'd3;
  localparam logic [2:0] S_POP_RD = 3'd4;
  localparam logic [2:0] S_POP_EX = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  trig_entry_t trig_mem [TRIGGERS];
  req_entry_t  req_mem [RDEPTH];
  trig_entry_t trig_rdata;
  req_entry_t  req_rdata;

  logic [2:0]    state;
  logic [AW-1:0] clr;
  logic [2:0]    op;
  logic [15:0]   key;
  logic [47:0]   time_ms;
  logic [47:0]   till_ms;
  logic [TW-1:0] t_idx;
  logic [RW-1:0] r_idx;
  logic          sat;
  logic          trig_any;
  logic          drop;
  logic          pop_v;
  logic [7:0]    pop_a;

  logic          trig_we;
  logic [TW-1:0] trig_waddr;
  trig_entry_t   trig_wdata;
  logic          req_we;
  logic [AW-1:0] req_waddr;
  req_entry_t    req_wdata;

  logic          match;
  logic [1:0]    ks_new;
  logic [1:0]    ks_eff;
  logic          req_ok;
  logic          sat_acc;
  logic          last_r;
  logic          fire;

  queue_ctl_t    q_ctl;
  qentry_t       q_wdata;
  qentry_t       q_rdata;
  queue_sts_t    q_sts;

  logic          accept;
  logic          trig_slot_ok;
  logic          req_slot_ok;

  assign req_ready    = (state == S_IDLE);
  assign accept       = req_valid && req_ready;
  assign trig_slot_ok = (32'(req.trigger_slot) < TRIGGERS);
  assign req_slot_ok  = trig_slot_ok && (32'(req.requirement_slot) < REQS);

  always_comb begin
    match   = req_rdata.en && trig_rdata.en && (req_rdata.key == key);
    ks_new  = (op == OP_PRESS) ?
              ((req_rdata.ks == KS_RELEASED) ? KS_FRESH : KS_HELD) : KS_RELEASED;
    ks_eff  = match ? ks_new : req_rdata.ks;
    req_ok  = !req_rdata.en ||
              (req_rdata.fresh ? (ks_eff == KS_FRESH) : (ks_eff != KS_RELEASED));
    sat_acc = sat && req_ok;
    last_r  = (r_idx == RW'(REQS - 1));
    fire    = (state == S_EX) && last_r && (op == OP_PRESS) &&
              trig_rdata.en && sat_acc;
  end

  always_comb begin
    trig_we    = 1'b0;
    trig_waddr = clr[AW-1:RW];
    trig_wdata = '0;
    req_we     = 1'b0;
    req_waddr  = clr;
    req_wdata  = '0;
    if (state == S_CLR) begin
      trig_we = 1'b1;
      req_we  = 1'b1;
    end else if (accept && req.operation == OP_WR_TRIG && trig_slot_ok) begin
      trig_we    = 1'b1;
      trig_waddr = TW'(req.trigger_slot);
      trig_wdata = '{en: req.entry_enable, action: req.entry_action};
    end else if (accept && req.operation == OP_WR_REQ && req_slot_ok) begin
      req_we    = 1'b1;
      req_waddr = {TW'(req.trigger_slot), RW'(req.requirement_slot)};
      req_wdata = '{en: req.entry_enable, fresh: req.entry_needs_fresh,
                    key: req.entry_key, ks: KS_RELEASED};
    end else if (state == S_EX && match) begin
      req_we    = 1'b1;
      req_waddr = {t_idx, r_idx};
      req_wdata = req_rdata;
      req_wdata.ks = ks_new;
    end
  end

  always_ff @(posedge clk) begin
    if (trig_we) begin
      trig_mem[trig_waddr] <= trig_wdata;
    end
    if (req_we) begin
      req_mem[req_waddr] <= req_wdata;
    end
    trig_rdata <= trig_mem[t_idx];
    req_rdata  <= req_mem[{t_idx, r_idx}];
  end

  always_comb begin
    q_ctl.push = fire && !q_sts.full;
    q_ctl.rd   = (state == S_POP_RD) && !q_sts.empty;
    q_ctl.pop  = (state == S_POP_EX) && (q_rdata.time_ms <= till_ms);
    q_wdata    = '{action: trig_rdata.action, time_ms: time_ms};
  end

  kcat_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .ctl   (q_ctl),
    .wdata (q_wdata),
    .rdata (q_rdata),
    .sts   (q_sts)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= req.operation;
      key     <= req.key_code;
      time_ms <= req.time_ms;
      till_ms <= req.till_ms;
    end
    if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp <= '{any_triggered: trig_any, popped_valid: pop_v,
               popped_action: pop_a, queue_dropped: drop};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      t_idx     <= '0;
      r_idx     <= '0;
      sat       <= 1'b1;
      trig_any  <= 1'b0;
      drop      <= 1'b0;
      pop_v     <= 1'b0;
      pop_a     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(RDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            t_idx    <= '0;
            r_idx    <= '0;
            sat      <= 1'b1;
            trig_any <= 1'b0;
            drop     <= 1'b0;
            pop_v    <= 1'b0;
            pop_a    <= '0;
            case (req.operation) inside
              OP_PRESS, OP_RELEASE: state <= S_RD;
              OP_POP:               state <= S_POP_RD;
              default:              state <= S_DONE;
            endcase
          end
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX: begin
          if (fire) begin
            trig_any <= 1'b1;
            if (q_sts.full) begin
              drop <= 1'b1;
            end
          end
          if (last_r) begin
            r_idx <= '0;
            sat   <= 1'b1;
            if (t_idx == TW'(TRIGGERS - 1)) begin
              t_idx <= '0;
              state <= S_DONE;
            end else begin
              t_idx <= t_idx + 1'b1;
              state <= S_RD;
            end
          end else begin
            r_idx <= r_idx + 1'b1;
            sat   <= sat_acc;
            state <= S_RD;
          end
        end
        S_POP_RD: begin
          state <= q_sts.empty ? S_DONE : S_POP_EX;
        end
        S_POP_EX: begin
          if (q_ctl.pop) begin
            pop_v <= 1'b1;
            pop_a <= q_rdata.action;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("Response transfer changed while it waited.");
  a_push_press: assert property (@(posedge clk) disable iff (rst)
    q_ctl.push |-> (op == OP_PRESS))
    else $error("Action queued outside a key press.");
  a_clr_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !req_ready)
    else $error("Request transfer offered during the clearing pass.");
`endif

endmodule

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// Key chord action trigger unit testbench
// Drives table writes, key presses and releases and action pops through the
// request channel, predicts every result from a model of the chord tables and
// the action queue, and checks each response transfer in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import kcat_pkg::*;

  localparam int NTRIG  = 16;
  localparam int NREQ   = 4;
  localparam int QDEPTH = 32;
  localparam int NUM_ITEMS = 1350;
  localparam longint CYCLE_LIMIT = 1500000;

  class chord_scoreboard;
    trig_entry_t trigs[NTRIG];
    req_entry_t  reqs[NTRIG*NREQ];
    qentry_t     actions[QDEPTH];
    int          head;
    int          count;
    result_t     pending[$];
    int          mismatches;

    function void clear();
      head = 0;
      count = 0;
      mismatches = 0;
      pending.delete();
      for (int t = 0; t < NTRIG; t++) trigs[t] = '0;
      for (int i = 0; i < NTRIG*NREQ; i++) reqs[i] = '0;
    endfunction

    function void note_item(item_t it);
      result_t res;
      logic    sat;
      int      idx;
      res = '0;
      case (it.operation)
        OP_PRESS: begin
          for (int t = 0; t < NTRIG; t++) begin
            if (!trigs[t].en) continue;
            sat = 1'b1;
            for (int r = 0; r < NREQ; r++) begin
              idx = t * NREQ + r;
              if (!reqs[idx].en) continue;
              if (reqs[idx].key == it.key_code)
                reqs[idx].ks = (reqs[idx].ks == KS_RELEASED) ? KS_FRESH : KS_HELD;
              if (reqs[idx].fresh) sat &= (reqs[idx].ks == KS_FRESH);
              else sat &= (reqs[idx].ks != KS_RELEASED);
            end
            if (sat) begin
              res.any_triggered = 1'b1;
              if (count >= QDEPTH) begin
                res.queue_dropped = 1'b1;
              end else begin
                actions[(head + count) % QDEPTH] = '{trigs[t].action, it.time_ms};
                count++;
              end
            end
          end
        end
        OP_RELEASE: begin
          for (int t = 0; t < NTRIG; t++) begin
            if (!trigs[t].en) continue;
            for (int r = 0; r < NREQ; r++) begin
              idx = t * NREQ + r;
              if (reqs[idx].en && reqs[idx].key == it.key_code) reqs[idx].ks = KS_RELEASED;
            end
          end
        end
        OP_POP: begin
          if (count > 0 && actions[head].time_ms <= it.till_ms) begin
            res.popped_valid = 1'b1;
            res.popped_action = actions[head].action;
            head = (head + 1) % QDEPTH;
            count--;
          end
        end
        OP_WR_TRIG: begin
          trigs[it.trigger_slot] = '{it.entry_enable, it.entry_action};
        end
        OP_WR_REQ: begin
          idx = it.trigger_slot * NREQ + it.requirement_slot;
          reqs[idx] = '{it.entry_enable, it.entry_needs_fresh, it.entry_key, KS_RELEASED};
        end
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.any_triggered !== want.any_triggered || got.popped_valid !== want.popped_valid ||
          got.popped_action !== want.popped_action ||
          got.queue_dropped !== want.queue_dropped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    req_valid;
  logic    req_ready;
  item_t   req;
  logic    rsp_valid;
  logic    rsp_ready;
  result_t rsp;
  longint  cycles;
  chord_scoreboard board;
  logic [15:0] key_pool[8];

  key_chord_action_trigger_unit dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  // The request valid stays high into a back-to-back transfer and is dropped
  // only when a gap follows.
  task automatic send_item(item_t it);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_item(it);
  endtask

  function automatic item_t random_fields();
    logic [159:0] bits;
    item_t it;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = bits[$bits(item_t)-1:0];
    return it;
  endfunction

  function automatic item_t make_press(logic [15:0] key, logic [47:0] t);
    item_t it;
    it = random_fields();
    it.operation = OP_PRESS;
    it.key_code = key;
    it.time_ms = t;
    return it;
  endfunction

  function automatic item_t make_op(logic [2:0] op);
    item_t it;
    it = random_fields();
    it.operation = op;
    return it;
  endfunction

  function automatic item_t make_trig(int slot, logic en, logic [7:0] act);
    item_t it;
    it = random_fields();
    it.operation = OP_WR_TRIG;
    it.trigger_slot = 4'(slot);
    it.entry_enable = en;
    it.entry_action = act;
    return it;
  endfunction

  function automatic item_t make_req(int slot, int rs, logic en, logic [15:0] key,
                                     logic fresh);
    item_t it;
    it = random_fields();
    it.operation = OP_WR_REQ;
    it.trigger_slot = 4'(slot);
    it.requirement_slot = 2'(rs);
    it.entry_enable = en;
    it.entry_key = key;
    it.entry_needs_fresh = fresh;
    return it;
  endfunction

  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return key_pool[$urandom_range(0, 7)];
  endfunction

  function automatic item_t random_item(ref logic [47:0] clock_ms);
    int      roll;
    item_t   it;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      clock_ms += 48'($urandom_range(0, 50));
      it = make_press(pick_key(), ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom})
                                                             : clock_ms);
    end else if (roll < 62) begin
      it = make_op(OP_RELEASE);
      it.key_code = pick_key();
    end else if (roll < 82) begin
      it = make_op(OP_POP);
      case ($urandom_range(0, 3))
        0: it.till_ms = '1;
        1: it.till_ms = '0;
        2: it.till_ms = 48'({$urandom, $urandom});
        default: it.till_ms = clock_ms - 48'($urandom_range(0, 100));
      endcase
    end else if (roll < 88) begin
      it = make_trig($urandom_range(0, NTRIG - 1), $urandom_range(0, 3) != 0,
                     8'($urandom));
    end else if (roll < 97) begin
      it = make_req($urandom_range(0, NTRIG - 1), $urandom_range(0, NREQ - 1),
                    $urandom_range(0, 3) != 0, pick_key(), 1'($urandom));
    end else begin
      it = make_op(3'($urandom_range(5, 7)));
    end
    return it;
  endfunction

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) board.check_result(rsp);
      if (gap_length() == 0 || $urandom_range(0, 1) == 0) rsp_ready <= 1'b1;
      else rsp_ready <= 1'b0;
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [47:0] clock_ms;
    board = new();
    board.clear();
    for (int k = 0; k < 8; k++) key_pool[k] = 16'($urandom);
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    clock_ms = 48'd1000;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_item(make_press(16'h0000, '0));
    send_item(make_op(OP_POP));
    send_item(make_trig(0, 1'b1, 8'hFF));
    send_item(make_press(16'h1234, '1));
    send_item(make_trig(15, 1'b1, 8'h00));
    send_item(make_req(15, 0, 1'b1, 16'hFFFF, 1'b1));
    send_item(make_req(15, 3, 1'b1, 16'h0000, 1'b0));
    send_item(make_press(16'hFFFF, 48'd5));
    send_item(make_press(16'h0000, 48'd6));
    send_item(make_press(16'hFFFF, 48'd7));
    send_item(make_op(OP_RELEASE));
    send_item(make_press(16'hFFFF, 48'd3));
    begin
      item_t p;
      p = make_op(OP_POP);
      p.till_ms = '0;
      send_item(p);
      p.till_ms = '1;
      repeat (4) send_item(p);
    end
    send_item(make_op(3'd5));
    send_item(make_op(3'd7));
    send_item(make_trig(15, 1'b0, 8'h5A));
    send_item(make_req(0, 2, 1'b0, 16'h0000, 1'b1));
    for (int k = 0; k < 20; k++) send_item(make_press(16'hAAAA, 48'd10 + 48'(k)));

    req_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);

    for (int n = 0; n < NUM_ITEMS; n++) begin
      send_item(random_item(clock_ms));
      if (n == NUM_ITEMS / 2) begin
        req_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
      end
    end

    req_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
